>>> src/lzc_pkg.sv
// Shared types, constants and CRC function for the LZ window expander.
`default_nettype none
package lzc_pkg;
	localparam logic [33:0] LIMIT_RESET = 34'h280000000;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;
	localparam logic [9:0] SYM_END = 10'd256;
	localparam logic [9:0] SYM_MAX = 10'd512;
	localparam logic [9:0] LEN_BIAS = 10'd254;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_DIST = 2'd1;
	localparam logic [1:0] ST_LIMIT = 2'd2;
	localparam logic [1:0] ST_CRC = 2'd3;

	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_ONE = 2'd1;
	localparam logic [1:0] ACT_MATCH = 2'd2;

	typedef struct packed {
		logic latch;
		logic single;
		logic start;
		logic rd;
		logic wr;
		logic emit;
	} lzc_cmd_t;

	typedef struct packed {
		logic [1:0] act;
		logic out_free;
		logic lane_done;
		logic rem_zero;
	} lzc_sts_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = (crc ^ CRC_ALL_ONES) ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c ^ CRC_ALL_ONES;
	endfunction
endpackage
`default_nettype wire

>>> src/lzc_ctrl.sv
// Controller state machine for the LZ window expander.
`default_nettype none
module lzc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire lzc_pkg::lzc_sts_t sts,
	output lzc_pkg::lzc_cmd_t    cmd
);
	import lzc_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_RD = 3'd2;
	localparam logic [2:0] S_WR = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				case (sts.act)
					ACT_NONE: state_d = S_IDLE;
					ACT_ONE: begin
						if (sts.out_free) begin
							cmd.single = 1'b1;
							state_d = S_IDLE;
						end
					end
					ACT_MATCH: begin
						cmd.start = 1'b1;
						state_d = S_RD;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = S_WR;
			end
			S_WR: begin
				cmd.wr = 1'b1;
				state_d = sts.lane_done ? S_EMIT : S_RD;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = sts.rem_zero ? S_IDLE : S_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

>>> src/lzc_dp.sv
// Datapath: history window, pointers, CRC, error state and output register.
`default_nettype none
module lzc_dp #(
	parameter int WINDOW_BYTES = 4096,
	parameter int LANE_BYTES = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lzc_pkg::lzc_cmd_t cmd,
	output lzc_pkg::lzc_sts_t      sts,
	input  wire logic              opcode,
	input  wire logic [9:0]        symbol,
	input  wire logic [11:0]       distance,
	input  wire logic [31:0]       expected_crc,
	input  wire logic              cfg_we,
	input  wire logic [33:0]       cfg_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [63:0]            data_bytes,
	output logic [3:0]             byte_count,
	output logic                   last_of_run,
	output logic [31:0]            crc_value,
	output logic [1:0]             status
);
	import lzc_pkg::*;

	localparam int AW = $clog2(WINDOW_BYTES);
	localparam int SW = AW + 2;
	localparam logic [AW-1:0] WP_LAST = AW'(WINDOW_BYTES - 1);
	localparam logic [3:0] LANE_LAST = 4'(LANE_BYTES - 1);

	logic [7:0] mem [WINDOW_BYTES];
	logic [7:0] rdata_q;

	logic op_q;
	logic [9:0] sym_q;
	logic [11:0] dist_q;
	logic [31:0] exp_q;
	logic [33:0] limit_q;
	logic [AW-1:0] wp_q, src_q;
	logic [34:0] total_q;
	logic [31:0] crc_q;
	logic [1:0] err_q;
	logic [8:0] rem_q;
	logic [3:0] lane_n_q;
	logic [63:0] lane_data_q;

	logic is_lit, is_match, bad_dist, over, lit_ok;
	logic [8:0] len;
	logic [1:0] act, err_next;
	logic [SW-1:0] src_sum;
	logic [AW-1:0] src_start;
	logic [31:0] crc_lit, crc_wr;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0] wr_data;
	logic out_free;

	assign out_free = !out_valid || !out_stall;
	assign is_lit = (sym_q < SYM_END);
	assign is_match = (sym_q > SYM_END) && (sym_q <= SYM_MAX);
	assign len = is_lit ? 9'd1 : 9'(sym_q - LEN_BIAS);
	assign bad_dist = (dist_q == 12'd0) || (35'(dist_q) > total_q)
		|| (32'(dist_q) > 32'(WINDOW_BYTES));
	assign over = (36'(total_q) + 36'(len)) > 36'(limit_q);
	assign src_sum = SW'(wp_q) + SW'(WINDOW_BYTES) - SW'(dist_q);
	assign src_start = (src_sum >= SW'(WINDOW_BYTES)) ?
		AW'(src_sum - SW'(WINDOW_BYTES)) : AW'(src_sum);
	assign crc_lit = crc_byte(crc_q, sym_q[7:0]);
	assign crc_wr = crc_byte(crc_q, rdata_q);

	always_comb begin
		act = ACT_ONE;
		err_next = err_q;
		lit_ok = 1'b0;
		if (op_q) begin
			if (err_q == ST_OK && crc_q != exp_q) begin
				err_next = ST_CRC;
			end
		end else if (!is_lit && !is_match) begin
			act = ACT_NONE;
		end else if (err_q != ST_OK) begin
			act = ACT_ONE;
		end else if (is_match && bad_dist) begin
			err_next = ST_BAD_DIST;
		end else if (over) begin
			err_next = ST_LIMIT;
		end else if (is_lit) begin
			lit_ok = 1'b1;
		end else begin
			act = ACT_MATCH;
		end
	end

	assign sts.act = act;
	assign sts.out_free = out_free;
	assign sts.lane_done = (lane_n_q == LANE_LAST) || (rem_q == 9'd1);
	assign sts.rem_zero = (rem_q == 9'd0);

	assign wr_en = cmd.wr || (cmd.single && lit_ok);
	assign wr_addr = wp_q;
	assign wr_data = cmd.wr ? rdata_q : sym_q[7:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= mem[src_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= opcode;
			sym_q <= symbol;
			dist_q <= distance;
			exp_q <= expected_crc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			src_q <= '0;
			total_q <= '0;
			crc_q <= '0;
			err_q <= ST_OK;
			rem_q <= '0;
			lane_n_q <= '0;
			lane_data_q <= '0;
			out_valid <= 1'b0;
			data_bytes <= '0;
			byte_count <= '0;
			last_of_run <= 1'b0;
			crc_value <= '0;
			status <= ST_OK;
		end else begin
			if (cmd.single || cmd.emit) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (wr_en) begin
				wp_q <= (wp_q == WP_LAST) ? '0 : wp_q + 1'b1;
			end
			if (cmd.single) begin
				err_q <= err_next;
				last_of_run <= 1'b1;
				if (lit_ok) begin
					total_q <= total_q + 35'd1;
					crc_q <= crc_lit;
					data_bytes <= {56'd0, sym_q[7:0]};
					byte_count <= 4'd1;
					crc_value <= crc_lit;
					status <= ST_OK;
				end else begin
					data_bytes <= '0;
					byte_count <= '0;
					crc_value <= crc_q;
					status <= err_next;
				end
			end
			if (cmd.start) begin
				total_q <= total_q + 35'(len);
				rem_q <= len;
				src_q <= src_start;
				lane_n_q <= '0;
				lane_data_q <= '0;
			end
			if (cmd.rd) begin
				src_q <= (src_q == WP_LAST) ? '0 : src_q + 1'b1;
			end
			if (cmd.wr) begin
				crc_q <= crc_wr;
				lane_data_q <= lane_data_q | (64'(rdata_q) << {lane_n_q, 3'b000});
				lane_n_q <= lane_n_q + 4'd1;
				rem_q <= rem_q - 9'd1;
			end
			if (cmd.emit) begin
				data_bytes <= lane_data_q;
				byte_count <= lane_n_q;
				last_of_run <= (rem_q == 9'd0);
				crc_value <= crc_q;
				status <= ST_OK;
				lane_n_q <= '0;
				lane_data_q <= '0;
			end
		end
	end

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != ST_OK |=> err_q == $past(err_q))
		else $error("error code changed after being set");
	a_bytes_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_count != 4'd0 |-> status == ST_OK)
		else $error("data bytes with error status");
	a_lane_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_count <= 4'(LANE_BYTES))
		else $error("byte count beyond lane width");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.single) |-> out_free)
		else $error("output register overwritten");
endmodule
`default_nettype wire

>>> src/lz_window_expander_crc32.sv
// Top level of the LZ window expander with running CRC-32.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, opcode, symbol,       | into block
//          | distance, expected_crc                    |
//  out     | out_valid, out_stall, data_bytes,         | out of block
//          | byte_count, last_of_run, crc_value, status|
//  cfg     | cfg_valid, cfg_ready, cfg_data            | into block
//
// One item is in flight at a time; in_stall is low only while idle.
// Literal, error, finish and ignored items pass through the decide state only; a match does
// one window read and one write per byte and emits each lane of up to LANE_BYTES bytes.
// Reset clears pointers, CRC, output total and error; the window is not cleared.
// A stalled output holds the next result and the copy waits until it moves.
`default_nettype none
module lz_window_expander_crc32 #(
	parameter int WINDOW_BYTES = 4096,
	parameter int LANE_BYTES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [9:0]  symbol,
	input  wire logic [11:0] distance,
	input  wire logic [31:0] expected_crc,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      data_bytes,
	output logic [3:0]       byte_count,
	output logic             last_of_run,
	output logic [31:0]      crc_value,
	output logic [1:0]       status,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [33:0] cfg_data
);
	import lzc_pkg::*;

	lzc_cmd_t cmd;
	lzc_sts_t sts;

	assign cfg_ready = 1'b1;

	lzc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts(sts),
		.cmd(cmd)
	);

	lzc_dp #(
		.WINDOW_BYTES(WINDOW_BYTES),
		.LANE_BYTES(LANE_BYTES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.opcode(opcode),
		.symbol(symbol),
		.distance(distance),
		.expected_crc(expected_crc),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_bytes(data_bytes),
		.byte_count(byte_count),
		.last_of_run(last_of_run),
		.crc_value(crc_value),
		.status(status)
	);
endmodule
`default_nettype wire

>>> dv/lz_window_expander_crc32_tb.sv
// Self-checking testbench for the LZ window expander with running CRC-32.
`default_nettype none
module lz_window_expander_crc32_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lzc_pkg::*;

	localparam logic OP_TOKEN = 1'b0;
	localparam logic OP_FINISH = 1'b1;
	localparam int WIN = 4096;
	localparam int LANES = 8;
	localparam int SETTLE_CYCLES = 600;
	localparam int WATCHDOG_CYCLES = 5000;
	localparam logic [33:0] LIMIT_MAX = 34'h3FFFFFFFF;

	typedef struct {
		logic op;
		logic [9:0] sym;
		logic [11:0] offset;
		logic [31:0] ecrc;
		bit crc_good;
		bit drain;
	} token_t;

	typedef struct {
		logic [63:0] data;
		logic [3:0] count;
		logic last;
		logic [31:0] crc;
		logic [1:0] st;
	} lane_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = 1'b0;
	logic [9:0] symbol = '0;
	logic [11:0] distance = '0;
	logic [31:0] expected_crc = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [63:0] data_bytes;
	logic [3:0] byte_count;
	logic last_of_run;
	logic [31:0] crc_value;
	logic [1:0] status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [33:0] cfg_data = '0;

	lz_window_expander_crc32 u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .symbol(symbol),
		.distance(distance), .expected_crc(expected_crc),
		.out_valid(out_valid), .out_stall(out_stall), .data_bytes(data_bytes),
		.byte_count(byte_count), .last_of_run(last_of_run), .crc_value(crc_value),
		.status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	token_t token_q[$];
	lane_t lane_q[$];
	int fails = 0;
	bit calm = 0;
	bit in_took = 0;
	int in_gap = 0;
	int stall_cnt = 0;
	int idle_cycles = 0;

	// expander shadow
	logic [7:0] hist[WIN];
	logic [11:0] wptr = '0;
	logic [34:0] total = '0;
	logic [31:0] crc = '0;
	logic [1:0] err = ST_OK;
	logic [33:0] limit = LIMIT_RESET;

	// generator bookkeeping
	longint gen_total = 0;
	longint gen_limit = 0;
	bit gen_err = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] crc_step(logic [31:0] c_in, logic [7:0] b);
		logic [31:0] c;
		c = ~c_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return ~c;
	endfunction

	function automatic void push_lane(logic [63:0] d, logic [3:0] n, logic l, logic [1:0] s);
		lane_t r;
		r.data = d;
		r.count = n;
		r.last = l;
		r.crc = crc;
		r.st = s;
		lane_q.push_back(r);
	endfunction

	function automatic void expand_token(token_t t);
		int len;
		int n;
		logic [11:0] src;
		logic [63:0] d;
		logic [7:0] b;
		if (t.op == OP_FINISH) begin
			if (err == ST_OK && crc != t.ecrc) err = ST_CRC;
			push_lane('0, 4'd0, 1'b1, err);
			return;
		end
		if (t.sym == SYM_END || t.sym > SYM_MAX) return;
		if (err != ST_OK) begin
			push_lane('0, 4'd0, 1'b1, err);
			return;
		end
		len = (t.sym < SYM_END) ? 1 : int'(t.sym) - int'(LEN_BIAS);
		if (t.sym > SYM_END && (t.offset == 0 || 35'(t.offset) > total)) begin
			err = ST_BAD_DIST;
			push_lane('0, 4'd0, 1'b1, err);
			return;
		end
		if (total + 35'(len) > {1'b0, limit}) begin
			err = ST_LIMIT;
			push_lane('0, 4'd0, 1'b1, err);
			return;
		end
		total += 35'(len);
		if (t.sym < SYM_END) begin
			hist[wptr] = t.sym[7:0];
			wptr++;
			crc = crc_step(crc, t.sym[7:0]);
			push_lane({56'd0, t.sym[7:0]}, 4'd1, 1'b1, ST_OK);
			return;
		end
		src = wptr - t.offset;
		while (len > 0) begin
			d = '0;
			n = 0;
			while (n < LANES && len > 0) begin
				b = hist[src];
				src++;
				hist[wptr] = b;
				wptr++;
				crc = crc_step(crc, b);
				d[8*n +: 8] = b;
				n++;
				len--;
			end
			push_lane(d, 4'(n), len == 0, ST_OK);
		end
	endfunction

	task automatic add(logic op, logic [9:0] sym, logic [11:0] offset, logic [31:0] ecrc,
			bit good, bit drain);
		token_t t;
		longint len;
		t.op = op;
		t.sym = sym;
		t.offset = offset;
		t.ecrc = ecrc;
		t.crc_good = good;
		t.drain = drain;
		token_q.push_back(t);
		if (op == OP_FINISH || sym == SYM_END || sym > SYM_MAX || gen_err) return;
		len = (sym < SYM_END) ? 1 : longint'(sym) - 254;
		if (sym > SYM_END && (offset == 0 || offset > gen_total)) gen_err = 1;
		else if (gen_total + len > gen_limit) gen_err = 1;
		else gen_total += len;
	endtask

	task automatic add_random(bit legal);
		int r;
		int dmax;
		logic [11:0] offset;
		r = $urandom_range(0, 99);
		dmax = (gen_total > 4095) ? 4095 : int'(gen_total);
		offset = (dmax == 0) ? 12'd0 :
			($urandom_range(0, 3) == 0 ? 12'($urandom_range(1, dmax < 8 ? dmax : 8)) :
			12'($urandom_range(1, dmax)));
		if (!legal && $urandom_range(0, 4) == 0) offset = 12'($urandom);
		if (r < 86 && r >= 35 && dmax == 0) r = 0;
		if (r < 35 || r >= 95)
			add(OP_TOKEN, 10'($urandom_range(0, 255)), 12'($urandom), 32'($urandom), 0, 0);
		else if (r < 75)
			add(OP_TOKEN, 10'($urandom_range(257, 270)), offset, 32'($urandom), 0, 0);
		else if (r < 80)
			add(OP_TOKEN, 10'($urandom_range(257, 512)), offset, 32'($urandom), 0, 0);
		else if (r < 86)
			add(OP_TOKEN, (r == 80) ? SYM_END : 10'($urandom_range(513, 1023)),
				12'($urandom), 32'($urandom), 0, 0);
		else
			add(OP_FINISH, 10'($urandom), 12'($urandom), 32'($urandom),
				legal || $urandom_range(0, 1) == 0, $urandom_range(0, 9) == 0);
	endtask

	task automatic wait_idle();
		wait (token_q.size() == 0 && !in_valid && lane_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [33:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		gen_limit = v;
	endtask

	// reset and stimulus
	initial begin
		gen_limit = LIMIT_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		write_limit(LIMIT_MAX);

		add(OP_TOKEN, 10'd0, 12'hFFF, 32'hFFFFFFFF, 0, 0);
		add(OP_TOKEN, 10'd255, 12'h000, 32'h0, 0, 0);
		add(OP_TOKEN, SYM_END, 12'hABC, 32'h0, 0, 0);
		add(OP_TOKEN, 10'd1023, 12'h555, 32'h0, 0, 0);
		add(OP_TOKEN, 10'd513, 12'hAAA, 32'h0, 0, 0);
		add(OP_TOKEN, 10'd257, 12'd1, 32'h0, 0, 0);
		add(OP_TOKEN, 10'd512, 12'd1, 32'h0, 0, 0);
		add(OP_TOKEN, 10'h0A5, 12'h0, 32'h0, 0, 0);
		add(OP_TOKEN, 10'd264, 12'd2, 32'h0, 0, 0);
		add(OP_TOKEN, 10'd300, 12'(gen_total), 32'h0, 0, 0);
		add(OP_FINISH, 10'h3FF, 12'hFFF, 32'h0, 1, 1);
		add(OP_TOKEN, 10'h05A, 12'h0, 32'h0, 0, 0);
		add(OP_FINISH, 10'd0, 12'd0, 32'h0, 1, 0);
		repeat (420) add_random(1);
		while (gen_total < 4095) add(OP_TOKEN, SYM_MAX, 12'd1, 32'h0, 0, 0);
		add(OP_TOKEN, SYM_MAX, 12'd4095, 32'h0, 0, 0);
		add(OP_FINISH, 10'd0, 12'd0, 32'h0, 1, 0);
		wait_idle();

		write_limit(LIMIT_RESET);
		repeat (15) add_random(1);
		wait_idle();

		write_limit(34'(gen_total + 100));
		for (int i = 0; i < 80 && !gen_err; i++) add_random(1);
		add(OP_TOKEN, 10'd300, 12'd0, 32'h0, 0, 0);
		add(OP_TOKEN, 10'd65, 12'd0, 32'h0, 0, 0);
		add(OP_FINISH, 10'd0, 12'd0, 32'($urandom), 0, 0);
		wait_idle();

		write_limit('0);
		calm = 1;
		repeat (20) add_random(0);
		wait_idle();
		if (fails == 0) $display("lz_window_expander_crc32 test passed");
		else $display("lz_window_expander_crc32 test failed");
		$finish;
	end

	// input driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_took) begin
			in_valid <= 1'b1;
		end else if (in_gap > 0) begin
			in_gap <= in_gap - 1;
			in_valid <= 1'b0;
		end else if (token_q.size() != 0 && !(token_q[0].drain && lane_q.size() != 0)) begin
			token_t t;
			t = token_q.pop_front();
			opcode <= t.op;
			symbol <= t.sym;
			distance <= t.offset;
			expected_crc <= t.crc_good ? crc : t.ecrc;
			in_valid <= 1'b1;
			if (!calm && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 15);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// output stall bursts
	always @(negedge clk) begin
		if (stall_cnt > 0) begin
			stall_cnt <= stall_cnt - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (!calm && $urandom_range(0, 9) == 0) stall_cnt <= $urandom_range(1, 15);
		end
	end

	// transfer monitor and watchdog
	always @(posedge clk) begin
		token_t t;
		lane_t e;
		in_took <= in_valid && !in_stall;
		if (in_valid && !in_stall) begin
			t.op = opcode;
			t.sym = symbol;
			t.offset = distance;
			t.ecrc = expected_crc;
			expand_token(t);
		end
		if (cfg_valid && cfg_ready) limit = cfg_data;
		if (out_valid && !out_stall) begin
			if (lane_q.size() == 0) begin
				$error("result with no expectation waiting");
				fails++;
			end else begin
				e = lane_q.pop_front();
				if (data_bytes !== e.data) begin
					$error("data_bytes expected %h got %h", e.data, data_bytes);
					fails++;
				end
				if (byte_count !== e.count) begin
					$error("byte_count expected %0d got %0d", e.count, byte_count);
					fails++;
				end
				if (last_of_run !== e.last) begin
					$error("last_of_run expected %0d got %0d", e.last, last_of_run);
					fails++;
				end
				if (crc_value !== e.crc) begin
					$error("crc_value expected %h got %h", e.crc, crc_value);
					fails++;
				end
				if (status !== e.st) begin
					$error("status expected %0d got %0d", e.st, status);
					fails++;
				end
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles + 1 >= WATCHDOG_CYCLES) begin
			$display("lz_window_expander_crc32 test failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end
endmodule
`default_nettype wire
